// ----- hdl/cld_pkg.sv -----
// cld_pkg: constants and conversion functions for the capacitor link deframer.
// No dependencies.
`default_nettype none
package cld_pkg;
    localparam logic [7:0]  FLAG_BYTE  = 8'hFF;
    localparam logic [3:0]  CLOSE_DIST = 4'd11;
    localparam logic [3:0]  DIST_SAT   = 4'd12;
    localparam logic [31:0] F32_120    = 32'h42F00000;
    localparam logic [31:0] F32_25     = 32'h41C80000;
    localparam logic [31:0] F32_ONE    = 32'h3F800000;

    // half-style word to float32 bits, no subnormal handling
    function automatic logic [31:0] word_to_f32(input logic [15:0] w);
        logic [7:0] e;
        e = 8'({3'b000, w[14:10]}) + 8'h70;
        if (w == 16'h0000) begin
            return 32'h0;
        end
        return {w[15], e, w[9:0], 13'h0};
    endfunction

    function automatic logic [31:0] clamp_pos(input logic [31:0] f, input logic [31:0] hi);
        if (f[31]) begin
            return 32'h0;
        end
        return (f >= hi) ? hi : f;
    endfunction

    function automatic logic [31:0] clamp_top(input logic [31:0] f, input logic [31:0] hi);
        return (!f[31] && f >= hi) ? hi : f;
    endfunction
endpackage
`default_nettype wire

// ----- hdl/capacitor_link_deframer.sv -----
// capacitor_link_deframer: top level, frame tracker, decoder and result register.
// Depends on cld_pkg, cld_frame, cld_decode.
//
//   channel | direction | words
//   s_      | in        | rx_byte, batch_start
//   m_      | out       | four float32 readings, one per good id-0 frame
//
// One byte per cycle while s_ready is high. The closing byte's frame is
// snapshotted when it is taken, decoded from that snapshot and loaded into the
// output register once the output slot is free.
// Reset clears frame tracking, the batch count and the pipeline valids.
// A held result stalls input only when the decode stage also holds one.
`default_nettype none
module capacitor_link_deframer #(
    parameter int BUFFER_DEPTH = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_rx_byte,
    input  wire logic        s_batch_start,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [31:0]      m_chassis_power_bits,
    output logic [31:0]      m_limit_power_bits,
    output logic [31:0]      m_buffer_power_bits,
    output logic [31:0]      m_capacitor_level_bits
);
    logic        take, done, pend_reg, pass;
    logic [79:0] frame, hold_reg;
    logic [31:0] ch, lm, bf, cp;
    logic        adv;

    // stage valid moves on when output slot frees
    assign adv     = !m_valid || m_ready;
    assign s_ready = !pend_reg || adv;
    assign take    = s_valid && s_ready;

    cld_frame #(.BUFFER_DEPTH(BUFFER_DEPTH)) u_frame (
        .aclk, .aresetn, .take, .rx_byte(s_rx_byte), .batch_start(s_batch_start),
        .done, .frame
    );

    // snapshot of frame bytes at close
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= 1'b0;
        end else if (take) begin
            pend_reg <= done;
        end else if (adv) begin
            pend_reg <= 1'b0;
        end
        if (take && done) begin
            hold_reg <= frame;
        end
    end

    cld_decode u_dec (
        .frame(hold_reg), .pass, .chassis(ch), .limit(lm), .buffer(bf), .cap(cp)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (adv) begin
            m_valid <= pend_reg && pass;
        end
        if (adv && pend_reg) begin
            m_chassis_power_bits   <= ch;
            m_limit_power_bits     <= lm;
            m_buffer_power_bits    <= bf;
            m_capacitor_level_bits <= cp;
        end
    end
endmodule
`default_nettype wire

// ----- hdl/cld_frame.sv -----
// cld_frame: frame tracking, byte store and batch counter.
// Depends on cld_pkg.
`default_nettype none
module cld_frame #(
    parameter int BUFFER_DEPTH = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        take,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        batch_start,
    output logic             done,
    output logic [79:0]      frame
);
    localparam int CW = $clog2(BUFFER_DEPTH + 1);

    logic          open_reg, open_next;
    logic [3:0]    dist_reg, dist_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [7:0]    bytes_reg [10];
    logic          open_c;
    logic [3:0]    dist_c, d;
    logic          wr;

    // next frame state for one byte
    always_comb begin
        open_c    = batch_start ? 1'b0 : open_reg;
        dist_c    = batch_start ? 4'd0 : dist_reg;
        cnt_next  = batch_start ? '0 : cnt_reg;
        d         = (dist_c >= cld_pkg::DIST_SAT) ? cld_pkg::DIST_SAT : dist_c + 4'd1;
        open_next = open_c;
        dist_next = dist_c;
        done      = 1'b0;
        wr        = 1'b0;
        if (open_c) begin
            if (rx_byte == cld_pkg::FLAG_BYTE) begin
                done      = (d == cld_pkg::CLOSE_DIST);
                open_next = 1'b0;
                dist_next = 4'd0;
            end else begin
                wr        = (d <= 4'd10);
                dist_next = d;
            end
        end else if (rx_byte == cld_pkg::FLAG_BYTE) begin
            open_next = 1'b1;
            dist_next = 4'd0;
        end
        if (cnt_next < CW'(BUFFER_DEPTH)) begin
            cnt_next = cnt_next + CW'(1);
        end
        if (cnt_next >= CW'(BUFFER_DEPTH)) begin
            open_next = 1'b0;
            dist_next = 4'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            open_reg <= 1'b0;
            dist_reg <= 4'd0;
            cnt_reg  <= '0;
        end else if (take) begin
            open_reg <= open_next;
            dist_reg <= dist_next;
            cnt_reg  <= cnt_next;
        end
    end

    // byte store, offsets 1..10
    always_ff @(posedge aclk) begin
        if (take && wr) begin
            bytes_reg[d - 4'd1] <= rx_byte;
        end
    end

    always_comb begin
        for (int i = 0; i < 10; i++) begin
            frame[i*8 +: 8] = bytes_reg[i];
        end
    end
endmodule
`default_nettype wire

// ----- hdl/cld_decode.sv -----
// cld_decode: id check, masking and float conversion of a closed frame.
// Depends on cld_pkg.
`default_nettype none
module cld_decode (
    input  wire logic [79:0] frame,
    output logic             pass,
    output logic [31:0]      chassis,
    output logic [31:0]      limit,
    output logic [31:0]      buffer,
    output logic [31:0]      cap
);
    logic [7:0] data [8];
    logic [7:0] id_b, mask;

    always_comb begin
        id_b = frame[7:0];
        mask = frame[79:72];
        pass = (id_b[7:4] == ~id_b[3:0]) && (id_b[7:4] == 4'h0);
        for (int i = 0; i < 8; i++) begin
            data[i] = mask[i] ? 8'hFF : frame[(i+1)*8 +: 8];
        end
        chassis = cld_pkg::clamp_pos(cld_pkg::word_to_f32({data[0], data[1]}),
                                     cld_pkg::F32_120);
        limit   = cld_pkg::word_to_f32({data[2], data[3]});
        buffer  = cld_pkg::clamp_pos(cld_pkg::word_to_f32({data[4], data[5]}),
                                     cld_pkg::F32_25);
        cap     = cld_pkg::clamp_top(cld_pkg::word_to_f32({data[6], data[7]}),
                                     cld_pkg::F32_ONE);
    end
endmodule
`default_nettype wire

// ----- hdl/cld_checker.sv -----
// cld_checker: port-level assertions for capacitor_link_deframer, with bind.
// Depends on the top level's ports only.
`default_nettype none
module cld_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [31:0] m_chassis_power_bits,
    input wire logic [31:0] m_buffer_power_bits
);
    // held result keeps its valid and its chassis power data
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_chassis_power_bits))
        else $error("result changed while stalled");
    // chassis power never negative or above 120
    a_ch: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !m_chassis_power_bits[31] && m_chassis_power_bits <= 32'h42F00000)
        else $error("chassis power out of range");
    a_bf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !m_buffer_power_bits[31] && m_buffer_power_bits <= 32'h41C80000)
        else $error("buffer power out of range");
    // with output free, input is always ready
    a_rdy: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");
    // nothing appears out of reset
    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("valid after reset");
endmodule

bind capacitor_link_deframer cld_checker u_cld_checker (
    .aclk, .aresetn, .s_valid, .s_ready, .m_valid, .m_ready,
    .m_chassis_power_bits, .m_buffer_power_bits
);
`default_nettype wire

// ----- test/tb_top.sv -----
// tb_top: self-checking testbench for capacitor_link_deframer.
// Depends on cld_pkg (flag byte, float32 limits) and the capacitor_link_deframer RTL.
`default_nettype none
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int BATCH_DEPTH = 256;
    localparam int PHASE_ITEMS = 500;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       batch_start;
    } link_word_t;

    typedef struct packed {
        logic [31:0] chassis;
        logic [31:0] limit;
        logic [31:0] buffer;
        logic [31:0] cap_level;
    } readings_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        s_batch_start = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_chassis_power_bits;
    logic [31:0] m_limit_power_bits;
    logic [31:0] m_buffer_power_bits;
    logic [31:0] m_capacitor_level_bits;

    capacitor_link_deframer #(.BUFFER_DEPTH(BATCH_DEPTH)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_rx_byte(s_rx_byte), .s_batch_start(s_batch_start),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_chassis_power_bits(m_chassis_power_bits),
        .m_limit_power_bits(m_limit_power_bits),
        .m_buffer_power_bits(m_buffer_power_bits),
        .m_capacitor_level_bits(m_capacitor_level_bits)
    );

    link_word_t pending_words[$];
    readings_t  expected_readings[$];
    int         mismatch_count = 0;
    int         send_idle_pct = 31;
    int         recv_idle_pct = 74;
    bit         stim_done = 1'b0;

    // shadow copy of the deframer state
    bit         shadow_open = 1'b0;
    int         shadow_dist = 0;
    logic [7:0] shadow_bytes[10];
    int         shadow_batch = 0;

    initial begin
        forever #10 aclk = ~aclk;
    end

    function automatic logic [31:0] half_to_f32(logic [15:0] w);
        logic [7:0] e;
        if (w == 16'h0) return 32'h0;
        e = {3'b000, w[14:10]} + 8'd112;
        return {w[15], e, w[9:0], 13'h0};
    endfunction

    function automatic logic [31:0] clip_range(logic [31:0] f, logic [31:0] hi, bit floor0);
        if (f[31]) return floor0 ? 32'h0 : f;
        return (f >= hi) ? hi : f;
    endfunction

    // append one word to the tail of the stimulus queue
    task automatic append_word(link_word_t w);
        pending_words = {pending_words, w};
    endtask

    task automatic drop_frame();
        shadow_open = 1'b0;
        shadow_dist = 0;
    endtask

    // decode a closed frame into readings, if its id is zero and checks out
    task automatic decode_frame();
        logic [7:0] data[8];
        readings_t r;
        if (shadow_bytes[0] != 8'h0F) return;
        for (int i = 0; i < 8; i++)
            data[i] = shadow_bytes[9][i] ? 8'hFF : shadow_bytes[1 + i];
        r.chassis   = clip_range(half_to_f32({data[0], data[1]}), cld_pkg::F32_120, 1'b1);
        r.limit     = half_to_f32({data[2], data[3]});
        r.buffer    = clip_range(half_to_f32({data[4], data[5]}), cld_pkg::F32_25, 1'b1);
        r.cap_level = clip_range(half_to_f32({data[6], data[7]}), cld_pkg::F32_ONE, 1'b0);
        expected_readings = {expected_readings, r};
    endtask

    task automatic track_word(link_word_t w);
        int d;
        if (w.batch_start) begin
            drop_frame();
            shadow_batch = 0;
        end
        if (shadow_open) begin
            d = (shadow_dist + 1 > 12) ? 12 : shadow_dist + 1;
            if (w.rx_byte == cld_pkg::FLAG_BYTE) begin
                if (d == 11) decode_frame();
                drop_frame();
            end else begin
                if (d >= 1 && d <= 10) shadow_bytes[d - 1] = w.rx_byte;
                shadow_dist = d;
            end
        end else if (w.rx_byte == cld_pkg::FLAG_BYTE) begin
            shadow_open = 1'b1;
            shadow_dist = 0;
        end
        if (shadow_batch < BATCH_DEPTH) shadow_batch++;
        if (shadow_batch >= BATCH_DEPTH) drop_frame();
    endtask

    // queue one well-formed frame; id byte and payload given
    task automatic queue_frame(logic [7:0] id_byte, logic [7:0] data[8], logic [7:0] mask,
                               bit first_batch);
        append_word('{cld_pkg::FLAG_BYTE, first_batch});
        append_word('{id_byte, 1'b0});
        for (int i = 0; i < 8; i++) append_word('{data[i], 1'b0});
        append_word('{mask, 1'b0});
        append_word('{cld_pkg::FLAG_BYTE, 1'b0});
    endtask

    function automatic logic [7:0] rand_data_byte();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFE;
            2: return {1'b1, 7'($urandom)};
            default: return 8'($urandom_range(0, 254));
        endcase
    endfunction

    task automatic queue_random_frame();
        logic [7:0] data[8];
        logic [7:0] id_byte;
        logic [7:0] mask;
        int k;
        for (int i = 0; i < 8; i++) data[i] = rand_data_byte();
        id_byte = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(0, 254)) : 8'h0F;
        mask = ($urandom_range(0, 2) == 0) ? 8'($urandom) : 8'h00;
        if (mask == 8'hFF) mask = 8'h7F;
        k = $urandom_range(0, 9);
        if (k == 0) begin
            // broken: short frame
            append_word('{cld_pkg::FLAG_BYTE, 1'b0});
            for (int i = 0; i < $urandom_range(0, 9); i++)
                append_word('{rand_data_byte(), 1'b0});
            append_word('{cld_pkg::FLAG_BYTE, 1'b0});
        end else if (k == 1) begin
            // noise
            for (int i = 0; i < $urandom_range(1, 6); i++)
                append_word('{8'($urandom), $urandom_range(0, 7) == 0});
        end else begin
            queue_frame(id_byte, data, mask, $urandom_range(0, 6) == 0);
        end
    endtask

    task automatic wait_drained();
        while (pending_words.size() != 0 || expected_readings.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
    endtask

    // stimulus
    initial begin
        logic [7:0] d[8];
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        // directed: zero word, max exponent, negative, clamps, mask, bad id, wrong distance
        d = '{8'h00, 8'h00, 8'h7B, 8'hFF, 8'h80, 8'h01, 8'hBC, 8'h00};
        queue_frame(8'h0F, d, 8'h00, 1'b1);
        d = '{8'h57, 8'h80, 8'hFC, 8'h00, 8'h4E, 8'h40, 8'h3C, 8'h01};
        queue_frame(8'h0F, d, 8'h00, 1'b0);
        d = '{8'h12, 8'h34, 8'h56, 8'h78, 8'h4E, 8'h3F, 8'h3B, 8'hFE};
        queue_frame(8'h0F, d, 8'hA5, 1'b0);
        queue_frame(8'h1E, d, 8'h00, 1'b0);
        queue_frame(8'h0E, d, 8'h00, 1'b0);
        queue_frame(8'h0F, d, 8'h80, 1'b0);
        for (int i = 0; i < 3; i++) append_word('{8'h00, 1'b0});
        append_word('{cld_pkg::FLAG_BYTE, 1'b0});
        // batch overflow: a long filler run, then a frame that must be dropped
        for (int i = 0; i < BATCH_DEPTH; i++) append_word('{8'h5A, 1'b0});
        queue_frame(8'h0F, d, 8'h00, 1'b0);
        queue_frame(8'h0F, d, 8'h00, 1'b1);
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 74 : 0;
            recv_idle_pct = (phase == 0) ? 74 : (phase == 1) ? 31 : 0;
            for (int n = 0; n < PHASE_ITEMS; n += 12) queue_random_frame();
            wait_drained();
        end
        stim_done = 1'b1;
    end

    // driver
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            track_word('{s_rx_byte, s_batch_start});
            void'(pending_words.pop_front());
        end
        if (aresetn && !(s_valid && !s_ready)) begin
            if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                s_valid <= 1'b1;
                s_rx_byte <= pending_words[0].rx_byte;
                s_batch_start <= pending_words[0].batch_start;
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    // monitor
    always @(posedge aclk) begin
        readings_t exp_r;
        readings_t got;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_chassis_power_bits, m_limit_power_bits,
                    m_buffer_power_bits, m_capacitor_level_bits};
            if (expected_readings.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h", got);
            end else begin
                exp_r = expected_readings.pop_front();
                if (got !== exp_r) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: chassis %h/%h limit %h/%h buffer %h/%h cap %h/%h",
                                 exp_r.chassis, got.chassis, exp_r.limit, got.limit,
                                 exp_r.buffer, got.buffer, exp_r.cap_level, got.cap_level);
                end
            end
        end
    end

    // final verdict
    initial begin
        wait (stim_done);
        if (mismatch_count == 0 && expected_readings.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    // run limit
    initial begin
        #2ms;
        $display("TEST FAILED");
        $finish;
    end
endmodule
`default_nettype wire
